@@ rtl/core/cies_pkg.sv @@
`timescale 1ns / 1ps

package cies_pkg;

    localparam int QUEUE_DEPTH = 4;

    // Request kinds
    localparam logic [2:0] KIND_RESET = 3'd0;
    localparam logic [2:0] KIND_NMI   = 3'd1;
    localparam logic [2:0] KIND_IRQ   = 3'd2;
    localparam logic [2:0] KIND_BRK   = 3'd3;
    localparam logic [2:0] KIND_RTI   = 3'd4;
    localparam logic [2:0] KIND_DATA  = 3'd5;

    // Bus operations on the result side
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_DONE  = 2'd2;

    // Status flags
    localparam logic [7:0] ST_I = 8'h04;
    localparam logic [7:0] ST_B = 8'h10;

    localparam logic [7:0]  STACK_PAGE = 8'h01;
    localparam logic [15:0] VEC_RESET  = 16'hFFFC;
    localparam logic [15:0] VEC_NMI    = 16'hFFFA;
    localparam logic [15:0] VEC_IRQ    = 16'hFFFE;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] cur_pc;
        logic [7:0]  cur_sp;
        logic [7:0]  cur_status;
        logic [7:0]  read_data;
    } req_t;

    typedef struct packed {
        logic [1:0]  bus_op;
        logic [15:0] bus_addr;
        logic [7:0]  bus_wdata;
        logic [15:0] new_pc;
        logic [7:0]  new_sp;
        logic [7:0]  new_status;
        logic        last;
    } rsp_t;

    // One queued command: an optional run of three stack pushes, then one closing word
    typedef struct packed {
        logic        has_push;
        logic [7:0]  push_sp;
        logic [7:0]  push_hi;
        logic [7:0]  push_lo;
        logic [7:0]  push_st;
        logic [1:0]  fin_op;
        logic [15:0] fin_addr;
        logic [15:0] fin_pc;
        logic [7:0]  fin_sp;
        logic [7:0]  fin_status;
    } cmd_t;

endpackage

@@ rtl/core/cpu_interrupt_entry_sequencer_top.sv @@
`timescale 1ns / 1ps

// Interrupt entry and return sequencer for an 8-bit CPU (reset, NMI, IRQ, BRK, RTI).
// Push a request word with the current PC, SP and status; the block answers with
// stack writes to page 1 and a bus read (none for a masked IRQ), then waits for a
// read-data word (kind 5) before issuing the next read, and closes with a finished
// word carrying the new PC, SP and status. The front takes one word per cycle while
// its command queue (QUEUE_DEPTH entries) has room; the back emits one result word
// per cycle while the result port is not stalled, so an NMI, BRK or unmasked IRQ
// request gives four result words (three pushes and a vector read), any other
// request or read-data word gives one, and stray data or an unknown kind gives none.
// A stalled pop holds the back, which in turn lets the queue fill and raise full. The
// result register lets a new word be accepted while an earlier result waits to be popped.
module cpu_interrupt_entry_sequencer_top #(
    parameter int QUEUE_DEPTH = cies_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  cies_pkg::req_t  req,
    output logic            empty,
    input  logic            pop,
    output cies_pkg::rsp_t  rsp
);
    import cies_pkg::*;

    logic q_full;
    logic q_empty;
    logic front_valid;
    logic cmd_pop;
    cmd_t front_cmd;
    cmd_t head_cmd;

    cies_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .q_full    (q_full),
        .cmd_valid (front_valid),
        .cmd       (front_cmd)
    );

    cies_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_cmd  (front_cmd),
        .q_full  (q_full),
        .q_empty (q_empty),
        .rd_en   (cmd_pop),
        .rd_cmd  (head_cmd)
    );

    cies_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    // writes never close an item; reads and finished words always do
    a_last_matches_op: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (rsp.last == (rsp.bus_op != OP_WRITE)))
        else $error("last flag does not match bus_op");

    a_push_on_stack_page: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (rsp.bus_op == OP_WRITE)) |-> (rsp.bus_addr[15:8] == STACK_PAGE))
        else $error("stack write outside page 1");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !q_empty)
        else $error("command taken from empty queue");

    a_full_blocks_front: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !front_valid)
        else $error("front wrote into full queue");
`endif

endmodule

@@ rtl/core/cies_front.sv @@
`timescale 1ns / 1ps

module cies_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  cies_pkg::req_t  req,
    input  logic            q_full,
    output logic            cmd_valid,
    output cies_pkg::cmd_t  cmd
);
    import cies_pkg::*;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_VLO  = 6'b000010,
        PH_VHI  = 6'b000100,
        PH_PST  = 6'b001000,
        PH_PLO  = 6'b010000,
        PH_PHI  = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  seq_kind_reg, seq_kind_next;
    logic [15:0] work_pc_reg, work_pc_next;
    logic [7:0]  work_sp_reg, work_sp_next;
    logic [7:0]  work_status_reg, work_status_next;
    logic [7:0]  low_byte_reg, low_byte_next;

    logic        accept;
    logic [15:0] vec_new;
    logic [15:0] vec_cur;
    logic [15:0] push_pc;
    logic [7:0]  push_status;
    logic [7:0]  sp_up;
    logic [15:0] pulled_pc;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        priority if (req.req_type == KIND_RESET)
            vec_new = VEC_RESET;
        else if (req.req_type == KIND_NMI)
            vec_new = VEC_NMI;
        else
            vec_new = VEC_IRQ;
        priority if (seq_kind_reg == KIND_RESET)
            vec_cur = VEC_RESET;
        else if (seq_kind_reg == KIND_NMI)
            vec_cur = VEC_NMI;
        else
            vec_cur = VEC_IRQ;
    end

    always_comb
    begin
        phase_next       = phase_reg;
        seq_kind_next    = seq_kind_reg;
        work_pc_next     = work_pc_reg;
        work_sp_next     = work_sp_reg;
        work_status_next = work_status_reg;
        low_byte_next    = low_byte_reg;
        cmd_valid        = 1'b0;
        cmd              = '0;
        push_pc          = (req.req_type == KIND_BRK) ? req.cur_pc + 16'd2 : req.cur_pc;
        push_status      = (req.req_type == KIND_BRK) ? (req.cur_status | ST_B)
                                                      : (req.cur_status & ~ST_B);
        sp_up            = work_sp_reg + 8'd1;
        pulled_pc        = {req.read_data, low_byte_reg};
        if ((seq_kind_reg == KIND_BRK) || (seq_kind_reg == KIND_RTI))
            pulled_pc = pulled_pc - 16'd1;

        if (accept)
        begin
            priority if (req.req_type <= KIND_RTI)
            begin
                seq_kind_next = req.req_type;
                work_pc_next  = req.cur_pc;
                cmd_valid     = 1'b1;
                cmd.fin_op    = OP_READ;
                priority if (req.req_type == KIND_RESET)
                begin
                    work_status_next = req.cur_status | ST_I;
                    work_sp_next     = req.cur_sp - 8'd3;
                    cmd.fin_addr     = vec_new;
                    phase_next       = PH_VLO;
                end
                else if (req.req_type == KIND_RTI)
                begin
                    work_status_next = req.cur_status;
                    work_sp_next     = req.cur_sp + 8'd1;
                    cmd.fin_addr     = {STACK_PAGE, req.cur_sp + 8'd1};
                    phase_next       = PH_PST;
                end
                else if ((req.req_type == KIND_IRQ) && ((req.cur_status & ST_I) != 8'd0))
                begin
                    // masked: finish at once, nothing changes
                    work_status_next = req.cur_status;
                    work_sp_next     = req.cur_sp;
                    cmd.fin_op       = OP_DONE;
                    cmd.fin_pc       = req.cur_pc;
                    cmd.fin_sp       = req.cur_sp;
                    cmd.fin_status   = req.cur_status;
                    phase_next       = PH_IDLE;
                end
                else
                begin
                    work_status_next = push_status | ST_I;
                    work_sp_next     = req.cur_sp - 8'd3;
                    cmd.has_push     = 1'b1;
                    cmd.push_sp      = req.cur_sp;
                    cmd.push_hi      = push_pc[15:8];
                    cmd.push_lo      = push_pc[7:0];
                    cmd.push_st      = push_status;
                    cmd.fin_addr     = vec_new;
                    phase_next       = PH_VLO;
                end
            end
            else if ((req.req_type == KIND_DATA) && (phase_reg != PH_IDLE))
            begin
                cmd_valid  = 1'b1;
                cmd.fin_op = OP_READ;
                unique case (phase_reg)
                    PH_VLO:
                    begin
                        low_byte_next = req.read_data;
                        cmd.fin_addr  = vec_cur + 16'd1;
                        phase_next    = PH_VHI;
                    end
                    PH_PST:
                    begin
                        work_status_next = req.read_data;
                        work_sp_next     = sp_up;
                        cmd.fin_addr     = {STACK_PAGE, sp_up};
                        phase_next       = PH_PLO;
                    end
                    PH_PLO:
                    begin
                        low_byte_next = req.read_data;
                        work_sp_next  = sp_up;
                        cmd.fin_addr  = {STACK_PAGE, sp_up};
                        phase_next    = PH_PHI;
                    end
                    default:
                    begin
                        // high byte arrived: close the sequence
                        work_pc_next   = pulled_pc;
                        cmd.fin_op     = OP_DONE;
                        cmd.fin_pc     = pulled_pc;
                        cmd.fin_sp     = work_sp_reg;
                        cmd.fin_status = work_status_reg;
                        phase_next     = PH_IDLE;
                    end
                endcase
            end
            else
            begin
                // drop: stray data or unknown kind
                cmd_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            seq_kind_reg    <= '0;
            work_pc_reg     <= '0;
            work_sp_reg     <= '0;
            work_status_reg <= '0;
            low_byte_reg    <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            seq_kind_reg    <= seq_kind_next;
            work_pc_reg     <= work_pc_next;
            work_sp_reg     <= work_sp_next;
            work_status_reg <= work_status_next;
            low_byte_reg    <= low_byte_next;
        end
    end

endmodule

@@ rtl/core/cies_queue.sv @@
`timescale 1ns / 1ps

module cies_queue #(
    parameter int DEPTH = cies_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  cies_pkg::cmd_t  wr_cmd,
    output logic            q_full,
    output logic            q_empty,
    input  logic            rd_en,
    output cies_pkg::cmd_t  rd_cmd
);
    import cies_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr;
    logic          do_rd;

    assign q_full  = (count_reg == CW'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_cmd  = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

@@ rtl/core/cies_back.sv @@
`timescale 1ns / 1ps

module cies_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  cies_pkg::cmd_t  cmd,
    output logic            cmd_pop,
    output logic            empty,
    input  logic            pop,
    output cies_pkg::rsp_t  rsp
);
    import cies_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    rsp_t       out_reg, out_next;
    logic       advance;

    assign empty   = !out_valid_reg;
    assign rsp     = out_reg;
    assign advance = !out_valid_reg || pop;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        if (advance)
        begin
            out_valid_next = cmd_valid;
            if (cmd_valid)
            begin
                out_next = '0;
                if (cmd.has_push && (idx_reg != 2'd3))
                begin
                    // stack push; SP drops by one per word
                    out_next.bus_op   = OP_WRITE;
                    out_next.bus_addr = {STACK_PAGE, cmd.push_sp - {6'd0, idx_reg}};
                    unique case (idx_reg)
                        2'd0:    out_next.bus_wdata = cmd.push_hi;
                        2'd1:    out_next.bus_wdata = cmd.push_lo;
                        default: out_next.bus_wdata = cmd.push_st;
                    endcase
                    idx_next = idx_reg + 2'd1;
                end
                else
                begin
                    out_next.bus_op     = cmd.fin_op;
                    out_next.bus_addr   = cmd.fin_addr;
                    out_next.new_pc     = cmd.fin_pc;
                    out_next.new_sp     = cmd.fin_sp;
                    out_next.new_status = cmd.fin_status;
                    out_next.last       = 1'b1;
                    idx_next            = 2'd0;
                    cmd_pop             = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule
